>>> hdl/hfgt_pkg.sv
// Shared types and constants for the height field grid triangulator.
// Holds register indexes, field widths and the line buffer sample layout.
// No dependencies.
package hfgt_pkg;

  localparam int COORD_W   = 32;
  localparam int ROW_LEN_W = 11;
  localparam int ROW_CNT_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_ADDR_W = 5;
  localparam int SAMPLE_W  = COORD_W + 1;
  localparam int OUT_DATA_W = 9 * COORD_W;

  localparam logic [CFG_IDX_W-1:0] CFG_X_START   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_START   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 3'd5;

  localparam logic [COORD_W-1:0]   X_START_RST   = 32'd0;
  localparam logic [COORD_W-1:0]   X_STEP_RST    = 32'd65536;
  localparam logic [COORD_W-1:0]   Y_START_RST   = 32'd0;
  localparam logic [COORD_W-1:0]   Y_STEP_RST    = 32'd65536;
  localparam logic [ROW_LEN_W-1:0] ROW_LEN_RST   = 11'd1024;
  localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RST = 16'd1024;

  typedef struct packed {
    logic                hole;
    logic [COORD_W-1:0]  height;
  } sample_t;

endpackage

>>> hdl/height_field_grid_triangulator.sv
// Height field grid triangulator: turns a raster of height samples into triangles.
// The input channel carries one height sample and its hole flag per beat; the
// output channel carries one triangle per beat, three vertices of x, y and z.
// A sample at column x > 0 and row y > 0 that is present, with its left, upper
// and upper-left neighbors present, yields two beats; the second has tlast set.
// Any other sample yields no beat. Rows are read in raster order, x fastest.
// The user must write the geometry registers over the APB-style port only while
// idle; the block does not enforce it. A sample passes stage 1, stage 2 and the
// output register. It takes one sample per cycle when it yields nothing and no pair
// waits on out_tready; a pair holds stage 2 until the output register takes both.
// The previous row lives in a line buffer RAM of MAX_ROW_LEN entries with a
// registered read; it needs no clearing, as row 0 never uses its contents.
// Reset clears the counters, the neighbor registers, the pipeline valid bits
// and restores the register defaults. When out_tready is low the output beat
// holds and the two pipeline stages fill; in_tready then falls.
// Depends on hfgt_pkg and hfgt_ram.
module height_field_grid_triangulator #(
  parameter int MAX_ROW_LEN = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hfgt_pkg::COORD_W-1:0]      in_tdata,   // height
  input  logic                              in_tuser,   // hole
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  output logic [hfgt_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [hfgt_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  localparam int CW = $clog2(MAX_ROW_LEN);
  localparam int LW = (CW + 1 > hfgt_pkg::ROW_LEN_W) ? CW + 1 : hfgt_pkg::ROW_LEN_W;
  localparam int RCW = hfgt_pkg::ROW_CNT_W;
  localparam int DW = hfgt_pkg::COORD_W;

  logic [DW-1:0]                  x_start_r, x_step_r, y_start_r, y_step_r;
  logic [hfgt_pkg::ROW_LEN_W-1:0] row_len_r;
  logic [RCW-1:0]                 row_count_r;
  logic                           cfg_wr;
  logic [hfgt_pkg::CFG_IDX_W-1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[hfgt_pkg::CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_start_r   <= hfgt_pkg::X_START_RST;
      x_step_r    <= hfgt_pkg::X_STEP_RST;
      y_start_r   <= hfgt_pkg::Y_START_RST;
      y_step_r    <= hfgt_pkg::Y_STEP_RST;
      row_len_r   <= hfgt_pkg::ROW_LEN_RST;
      row_count_r <= hfgt_pkg::ROW_COUNT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        hfgt_pkg::CFG_X_START:   x_start_r   <= cfg_pwdata;
        hfgt_pkg::CFG_X_STEP:    x_step_r    <= cfg_pwdata;
        hfgt_pkg::CFG_Y_START:   y_start_r   <= cfg_pwdata;
        hfgt_pkg::CFG_Y_STEP:    y_step_r    <= cfg_pwdata;
        hfgt_pkg::CFG_ROW_LEN:   row_len_r   <= cfg_pwdata[hfgt_pkg::ROW_LEN_W-1:0];
        hfgt_pkg::CFG_ROW_COUNT: row_count_r <= cfg_pwdata[RCW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      hfgt_pkg::CFG_X_START:   cfg_prdata = x_start_r;
      hfgt_pkg::CFG_X_STEP:    cfg_prdata = x_step_r;
      hfgt_pkg::CFG_Y_START:   cfg_prdata = y_start_r;
      hfgt_pkg::CFG_Y_STEP:    cfg_prdata = y_step_r;
      hfgt_pkg::CFG_ROW_LEN:   cfg_prdata = 32'(row_len_r);
      hfgt_pkg::CFG_ROW_COUNT: cfg_prdata = 32'(row_count_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // Raster counters and neighbor registers, advanced on every accepted beat.
  logic                in_acc;
  hfgt_pkg::sample_t   cur;
  logic [CW-1:0]       col_r, col_nxt;
  logic [RCW-1:0]      row_r, row_nxt;
  hfgt_pkg::sample_t   left_r;
  logic [LW-1:0]       len_eff, col_inc;
  logic [RCW-1:0]      cnt_eff;
  logic [RCW:0]        row_inc;

  assign cur = '{hole: in_tuser, height: in_tdata};

  always_comb begin
    if (row_len_r == '0) begin
      len_eff = LW'(1);
    end else if (LW'(row_len_r) > LW'(MAX_ROW_LEN)) begin
      len_eff = LW'(MAX_ROW_LEN);
    end else begin
      len_eff = LW'(row_len_r);
    end
    cnt_eff = (row_count_r == '0) ? RCW'(1) : row_count_r;
    col_inc = LW'(col_r) + LW'(1);
    row_inc = {1'b0, row_r} + (RCW + 1)'(1);
    if (col_inc >= len_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, cnt_eff}) ? '0 : row_inc[RCW-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = row_r;
    end
  end

  logic [hfgt_pkg::SAMPLE_W-1:0] up_rd;

  hfgt_ram #(
    .WIDTH (hfgt_pkg::SAMPLE_W),
    .DEPTH (MAX_ROW_LEN)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (col_r),
    .wr_data (cur),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (up_rd)
  );

  // Stage 1: accepted sample; the line buffer delivers its upper neighbor.
  logic              s1_valid_r, s1_valid_nxt, s1_move;
  hfgt_pkg::sample_t s1_cur_r, s1_left_r, s1_up, ul_r;
  logic [CW-1:0]     s1_x_r;
  logic [RCW-1:0]    s1_y_r;
  logic              s1_emit;
  logic [DW-1:0]     s1_xprod, s1_yprod;

  assign s1_up   = up_rd;
  assign s1_emit = !s1_cur_r.hole && (s1_x_r != '0) && (s1_y_r != '0) &&
                   !s1_left_r.hole && !s1_up.hole && !ul_r.hole;
  assign s1_xprod = {{(DW - CW){1'b0}}, s1_x_r} * x_step_r;
  assign s1_yprod = {{(DW - RCW){1'b0}}, s1_y_r} * y_step_r;

  // Stage 2: products registered; coordinates and triangles formed here.
  logic              s2_valid_r, s2_valid_nxt, s2_emit_r, s2_phase_r, s2_phase_nxt;
  logic              s2_done, s2_free;
  hfgt_pkg::sample_t s2_cur_r, s2_left_r, s2_up_r, s2_ul_r;
  logic [DW-1:0]     s2_xprod_r, s2_yprod_r;
  logic [DW-1:0]     px, lx, py, uy;

  // Output register.
  logic                          out_valid_r, out_valid_nxt, out_load_ok, out_load;
  logic [hfgt_pkg::OUT_DATA_W-1:0] out_data_r, tri_data;
  logic                          out_last_r;

  assign out_load_ok = !out_valid_r || out_tready;
  assign out_load    = s2_valid_r && s2_emit_r && out_load_ok;
  assign s2_done     = s2_valid_r && (!s2_emit_r || (out_load_ok && s2_phase_r));
  assign s2_free     = !s2_valid_r || s2_done;
  assign s1_move     = s1_valid_r && s2_free;
  assign in_tready   = !s1_valid_r || s1_move;
  assign in_acc      = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_move);
  assign s2_valid_nxt  = s1_move || (s2_valid_r && !s2_done);
  assign s2_phase_nxt  = s1_move ? 1'b0 : (out_load ? !s2_phase_r : s2_phase_r);
  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  always_comb begin
    px = x_start_r + s2_xprod_r;
    lx = px - x_step_r;
    py = y_start_r + s2_yprod_r;
    uy = py - y_step_r;
    if (!s2_phase_r) begin
      tri_data = {s2_up_r.height, uy, px,
                  s2_left_r.height, py, lx,
                  s2_cur_r.height, py, px};
    end else begin
      tri_data = {s2_left_r.height, py, lx,
                  s2_up_r.height, uy, px,
                  s2_ul_r.height, uy, lx};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      ul_r        <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s2_phase_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      s2_phase_r  <= s2_phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        left_r <= cur;
      end
      if (s1_move) begin
        ul_r <= s1_up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cur_r  <= cur;
      s1_left_r <= left_r;
      s1_x_r    <= col_r;
      s1_y_r    <= row_r;
    end
    if (s1_move) begin
      s2_cur_r   <= s1_cur_r;
      s2_left_r  <= s1_left_r;
      s2_up_r    <= s1_up;
      s2_ul_r    <= ul_r;
      s2_emit_r  <= s1_emit;
      s2_xprod_r <= s1_xprod;
      s2_yprod_r <= s1_yprod;
    end
    if (out_load) begin
      out_data_r <= tri_data;
      out_last_r <= s2_phase_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

>>> hdl/hfgt_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// A read and a write to the same address in one cycle return the old data.
// No dependencies.
module hfgt_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
